>>> src/srmt_pkg.sv
// ----------------------------------------------------------------------------
// srmt_pkg
// Shared types, codes and helpers for the sorted range membership table.
// ----------------------------------------------------------------------------
package srmt_pkg;

  localparam int ID_W    = 32;
  localparam int ENTRY_W = 2 * ID_W;
  localparam int CNT_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_INVALID   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN,
    S_DONE
  } state_t;

  // Entries are {start, end}; a plain compare gives start-then-end order.
  function automatic logic key_before(logic [ENTRY_W-1:0] a, logic [ENTRY_W-1:0] b);
    return a < b;
  endfunction

endpackage

>>> src/srmt_if.sv
// ----------------------------------------------------------------------------
// srmt_in_if / srmt_out_if
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srmt_in_if import srmt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      op;
  logic [ID_W-1:0] range_start;
  logic [ID_W-1:0] range_end;
  logic [ID_W-1:0] query_id;

  modport source (output valid, op, range_start, range_end, query_id, input ready);
  modport sink   (input valid, op, range_start, range_end, query_id, output ready);
endinterface

interface srmt_out_if import srmt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [1:0]       status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, hit, status, entry_count, input ready);
  modport sink   (input valid, hit, status, entry_count, output ready);
endinterface

>>> src/srmt_mem.sv
// ----------------------------------------------------------------------------
// srmt_mem
// Range store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srmt_mem import srmt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/srmt_ctrl.sv
// ----------------------------------------------------------------------------
// srmt_ctrl
// Sequencer: scans the range store one entry per cycle, shifts entries for
// insert and remove, evaluates queries, and holds the result register.
// ----------------------------------------------------------------------------
module srmt_ctrl import srmt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  srmt_in_if.sink            in_ch,
  srmt_out_if.source         out_ch,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr,
  input  logic [ENTRY_W-1:0] mem_rd_data,
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output logic [ENTRY_W-1:0] mem_wr_data
);

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [ENTRY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      ridx_r, ridx_nxt;
  logic               more_r, more_nxt;
  logic               pvalid_r, pvalid_nxt;
  logic [CW-1:0]      pidx_r, pidx_nxt;
  logic               found_r, found_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [ID_W-1:0]    prev_end_r, prev_end_nxt;
  logic               res_hit_r, res_hit_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic               accept;
  logic               bad_range;
  op_t                in_op;
  logic [CW-1:0]      count_dec;
  logic [CW-1:0]      up_idx;
  logic [CW-1:0]      dn_idx;
  logic               last;
  logic [ID_W-1:0]    d_start;
  logic [ID_W-1:0]    d_end;
  logic [ID_W-1:0]    qid;
  logic [31:0]        cnt_wide;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_op       = op_t'(in_ch.op);
  assign bad_range   = (in_ch.range_end < in_ch.range_start) ||
                       (in_ch.range_start == '1) || (in_ch.range_end == '1);
  assign count_dec   = count_r - CW'(1);
  assign up_idx      = pidx_r + CW'(1);
  assign dn_idx      = pidx_r - CW'(1);
  assign last        = (pidx_r == count_dec);
  assign d_start     = mem_rd_data[ENTRY_W-1:ID_W];
  assign d_end       = mem_rd_data[ID_W-1:0];
  assign qid         = key_r[ID_W-1:0];
  assign cnt_wide    = 32'(count_r);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    ridx_nxt       = ridx_r;
    more_nxt       = more_r;
    pvalid_nxt     = 1'b0;
    pidx_nxt       = pidx_r;
    found_nxt      = found_r;
    have_prev_nxt  = have_prev_r;
    prev_end_nxt   = prev_end_r;
    res_hit_nxt    = res_hit_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = '0;
    mem_wr_data    = key_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_op;
          key_nxt        = (in_op == OP_QUERY) ? {in_ch.query_id, in_ch.query_id}
                                               : {in_ch.range_start, in_ch.range_end};
          found_nxt      = 1'b0;
          have_prev_nxt  = 1'b0;
          more_nxt       = 1'b1;
          ridx_nxt       = (in_op == OP_INSERT) ? count_dec : '0;
          res_hit_nxt    = 1'b0;
          res_status_nxt = STATUS_OK;
          state_nxt      = S_DONE;
          case (in_op)
            OP_INSERT: begin
              if (bad_range) begin
                res_status_nxt = STATUS_INVALID;
              end else if (count_r == CW'(TABLE_DEPTH)) begin
                res_status_nxt = STATUS_FULL;
              end else if (count_r == '0) begin
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_RUN;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = STATUS_NOT_FOUND;
              end else begin
                state_nxt = S_RUN;
              end
            end
            OP_QUERY: begin
              if (count_r != '0) begin
                state_nxt = S_RUN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RUN: begin
        // Read issue: insert walks down from the top, the others walk up.
        if (more_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ridx_r[AW-1:0];
          pvalid_nxt  = 1'b1;
          pidx_nxt    = ridx_r;
          if (op_r == OP_INSERT) begin
            more_nxt = (ridx_r != '0);
            ridx_nxt = ridx_r - CW'(1);
          end else begin
            more_nxt = (ridx_r != count_dec);
            ridx_nxt = ridx_r + CW'(1);
          end
        end

        // Entry pidx_r arrives this cycle.
        if (pvalid_r) begin
          case (op_r)
            OP_INSERT: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = up_idx[AW-1:0];
              if (key_before(key_r, mem_rd_data)) begin
                mem_wr_data = mem_rd_data;
                if (pidx_r == '0) begin
                  state_nxt = S_FIN;
                end
              end else begin
                mem_wr_data = key_r;
                count_nxt   = count_r + CW'(1);
                state_nxt   = S_DONE;
              end
            end
            OP_REMOVE: begin
              if (found_r) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = dn_idx[AW-1:0];
                mem_wr_data = mem_rd_data;
              end else if (mem_rd_data == key_r) begin
                found_nxt = 1'b1;
              end
              if (last) begin
                state_nxt = S_DONE;
                if (found_r || (mem_rd_data == key_r)) begin
                  count_nxt = count_dec;
                end else begin
                  res_status_nxt = STATUS_NOT_FOUND;
                end
              end
            end
            OP_QUERY: begin
              if (key_before(mem_rd_data, key_r)) begin
                have_prev_nxt = 1'b1;
                prev_end_nxt  = d_end;
                if (last) begin
                  res_hit_nxt = (d_end >= qid);
                  state_nxt   = S_DONE;
                end
              end else begin
                res_hit_nxt = (d_start == qid) || (have_prev_r && (prev_end_r >= qid));
                state_nxt   = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
          if (state_nxt != S_RUN) begin
            pvalid_nxt = 1'b0;
            more_nxt   = 1'b0;
          end
        end
      end

      S_FIN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        mem_wr_data = key_r;
        count_nxt   = count_r + CW'(1);
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = res_hit_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = cnt_wide[CNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pvalid_r    <= 1'b0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pvalid_r    <= pvalid_nxt;
      more_r      <= more_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    ridx_r       <= ridx_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    have_prev_r  <= have_prev_nxt;
    prev_end_r   <= prev_end_nxt;
    res_hit_r    <= res_hit_nxt;
    res_status_r <= res_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

>>> src/sorted_range_membership_table.sv
// Sequencing: invalid, full, unused-op and empty-table lookup/remove requests go from
//   acceptance straight to the result state, an insert into an empty table via the final
//   write; scans read one entry per cycle, and an insert at the head also ends with that write.
// Throughput: one request at a time; the next is taken the cycle after its result is
//   registered, while that result waits on the output.
// Reset: synchronous, active low; the table comes up empty, store contents untouched.
// ----------------------------------------------------------------------------
// sorted_range_membership_table
// Sorted multiset of identifier ranges with insert, remove and lookup.
// ----------------------------------------------------------------------------
module sorted_range_membership_table import srmt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  srmt_in_if.sink    in_ch,
  srmt_out_if.source out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;

  srmt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  srmt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // Store is never written in the cycle a request is taken.
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> !(in_ch.valid && in_ch.ready))
    else $error("store write while accepting a request");

  // Only a successful query can report a hit.
  a_hit_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STATUS_OK)) |-> !out_ch.hit)
    else $error("hit with error status");

  // A full report carries the full count.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == STATUS_FULL)) |->
      (out_ch.entry_count == CNT_W'(TABLE_DEPTH)))
    else $error("full status with wrong count");

endmodule
